### hw/rtl/mpd_pkg.sv
package mpd_pkg;

  localparam logic [7:0] PUBLISH_HEADER = 8'h30;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_ABORT     = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       in_payload;
    logic       part_last;
    logic       packet_last;
    status_t    status;
  } result_t;

endpackage

### hw/rtl/mpd_if.sv
interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface mpd_out_if;
  import mpd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       in_payload;
  logic       part_last;
  logic       packet_last;
  status_t    status;

  modport source (output valid, output out_byte, output in_payload, output part_last,
                  output packet_last, output status, input ready);
  modport sink (input valid, input out_byte, input in_payload, input part_last,
                input packet_last, input status, output ready);
endinterface

interface mpd_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/mpd_step.sv
module mpd_step
  import mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       enable,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  output logic       result_valid,
  output result_t    result
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN1    = 3'd1,
    PH_LEN2    = 3'd2,
    PH_TLHI    = 3'd3,
    PH_TLLO    = 3'd4,
    PH_TOPIC   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  remaining_low, remaining_low_next;
  logic [13:0] remaining_left, remaining_left_next;
  logic [7:0]  topic_size_high, topic_size_high_next;
  logic [15:0] topic_left, topic_left_next;

  logic        len_done;
  logic        done;
  logic [13:0] total;
  logic [15:0] topic_size;
  logic [15:0] topic_dec;
  logic [13:0] left_dec;

  always_comb begin
    phase_next           = phase;
    remaining_low_next   = remaining_low;
    remaining_left_next  = remaining_left;
    topic_size_high_next = topic_size_high;
    topic_left_next      = topic_left;
    result_valid         = 1'b0;
    result               = '{out_byte: 8'd0, in_payload: 1'b0, part_last: 1'b0,
                             packet_last: 1'b1, status: ST_DATA};
    len_done             = 1'b0;
    done                 = 1'b0;
    total                = '0;
    topic_size           = {topic_size_high, rx_byte};
    topic_dec            = topic_left - {15'd0, topic_left != 16'd0};
    left_dec             = remaining_left - {13'd0, remaining_left != 14'd0};

    if (!enable) begin
      phase_next = PH_HUNT;
    end else begin
      unique case (phase)
        PH_LEN1: begin
          if (!rx_byte[7]) begin
            len_done = 1'b1;
            total    = {7'd0, rx_byte[6:0]};
          end else begin
            remaining_low_next = rx_byte[6:0];
            phase_next         = PH_LEN2;
          end
        end
        PH_LEN2: begin
          if (rx_byte[7]) begin
            result_valid  = 1'b1;
            result.status = ST_MALFORMED;
            phase_next    = PH_HUNT;
          end else begin
            len_done = 1'b1;
            total    = {rx_byte[6:0], remaining_low};
          end
        end
        PH_TLHI: begin
          topic_size_high_next = rx_byte;
          phase_next           = PH_TLLO;
        end
        PH_TLLO: begin
          if (topic_size > {2'b00, remaining_left}) begin
            result_valid  = 1'b1;
            result.status = ST_MALFORMED;
            phase_next    = PH_HUNT;
          end else begin
            topic_left_next     = topic_size;
            remaining_left_next = remaining_left - topic_size[13:0];
            if (topic_size == 16'd0 && remaining_left == 14'd0) begin
              result_valid  = 1'b1;
              result.status = ST_EMPTY;
              phase_next    = PH_HUNT;
            end else if (topic_size == 16'd0) begin
              phase_next = PH_PAYLOAD;
            end else begin
              phase_next = PH_TOPIC;
            end
          end
        end
        PH_TOPIC: begin
          topic_left_next        = topic_dec;
          result_valid           = 1'b1;
          result.out_byte        = rx_byte;
          result.part_last       = topic_dec == 16'd0;
          result.packet_last     = topic_dec == 16'd0 && remaining_left == 14'd0;
          if (topic_dec == 16'd0) begin
            if (remaining_left == 14'd0) begin
              done       = 1'b1;
              phase_next = PH_HUNT;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          remaining_left_next = left_dec;
          result_valid        = 1'b1;
          result.out_byte     = rx_byte;
          result.in_payload   = 1'b1;
          result.part_last    = left_dec == 14'd0;
          result.packet_last  = left_dec == 14'd0;
          if (left_dec == 14'd0) begin
            done       = 1'b1;
            phase_next = PH_HUNT;
          end
        end
        default: begin
          // hunting, and the unused code
          phase_next = (rx_byte == PUBLISH_HEADER) ? PH_LEN1 : PH_HUNT;
        end
      endcase

      if (len_done) begin
        if (total == 14'd0) begin
          result_valid  = 1'b1;
          result.status = ST_EMPTY;
          phase_next    = PH_HUNT;
        end else if (total == 14'd1) begin
          result_valid  = 1'b1;
          result.status = ST_MALFORMED;
          phase_next    = PH_HUNT;
        end else begin
          remaining_left_next = total - 14'd2;
          phase_next          = PH_TLHI;
        end
      end

      // drop a packet that the buffer end cuts short
      if (buffer_end && !done && phase_next != PH_HUNT) begin
        result_valid = 1'b1;
        result       = '{out_byte: 8'd0, in_payload: 1'b0, part_last: 1'b0,
                         packet_last: 1'b1, status: ST_ABORT};
        phase_next   = PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      remaining_low   <= '0;
      remaining_left  <= '0;
      topic_size_high <= '0;
      topic_left      <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      remaining_low   <= remaining_low_next;
      remaining_left  <= remaining_left_next;
      topic_size_high <= topic_size_high_next;
      topic_left      <= topic_left_next;
    end
  end

endmodule

### hw/rtl/mqtt_publish_deframer.sv
// A byte waits in the input register; its result, if any, in the result register.
// Throughput: one byte per cycle while not stalled; the parse state updates once
// per byte in a single pass between the input register and the result register.
// A stalled result register holds the input stage, which holds the rx channel.
// Reset (rst, synchronous): hunting for a header, counters cleared,
// parse_enable 0, both stages empty.
module mqtt_publish_deframer
  import mpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mpd_in_if.sink     rx,
  mpd_out_if.source  tx,
  mpd_cfg_if.sink    cfg
);

  logic       parse_enable;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_bend;
  logic       out_valid;
  result_t    out_result;
  logic       out_free;
  logic       advance;
  logic       step_valid;
  result_t    step_result;

  assign out_free = !out_valid || tx.ready;
  assign advance  = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;
  assign cfg.ready = 1'b1;

  mpd_step u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .enable       (parse_enable),
    .rx_byte      (in_byte),
    .buffer_end   (in_bend),
    .result_valid (step_valid),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_enable <= 1'b0;
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        parse_enable <= cfg.data;
      end
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= step_valid;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
      in_bend <= rx.buffer_end;
    end
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign tx.valid       = out_valid;
  assign tx.out_byte    = out_result.out_byte;
  assign tx.in_payload  = out_result.in_payload;
  assign tx.part_last   = out_result.part_last;
  assign tx.packet_last = out_result.packet_last;
  assign tx.status      = out_result.status;

  a_reset_empty: assert property (@(posedge clk) rst |=> !tx.valid)
    else $error("result shown after reset");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.status != ST_DATA |-> tx.out_byte == 8'd0 && tx.packet_last
      && !tx.part_last && !tx.in_payload)
    else $error("status result carries data");

  a_packet_end: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.status == ST_DATA && tx.packet_last |-> tx.part_last)
    else $error("packet ends inside a part");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && tx.valid && !tx.ready |=> in_valid && $stable(in_byte))
    else $error("input stage moved under a stalled result");

endmodule

### tb/mqtt_publish_deframer_tb.sv
`timescale 1ns / 100ps

module mqtt_publish_deframer_tb;
  import mpd_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    SEEK_HEADER,
    LEN_FIRST,
    LEN_SECOND,
    TLEN_HIGH,
    TLEN_LOW,
    TOPIC_BYTES,
    PAYLOAD_BYTES
  } parse_phase_t;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_CHOKED
  } sink_style_t;

  // {buffer_end, rx_byte}
  typedef logic [8:0] rx_item_t;

  class publish_scoreboard;
    logic         parse_enable;
    parse_phase_t phase;
    logic [6:0]   len_low;
    logic [13:0]  bytes_left;
    logic [7:0]   tlen_high;
    logic [15:0]  topic_left;
    result_t      predicted_results[$];
    int unsigned  mismatches;

    function new();
      parse_enable = 1'b0;
      phase        = SEEK_HEADER;
      len_low      = '0;
      bytes_left   = '0;
      tlen_high    = '0;
      topic_left   = '0;
      mismatches   = 0;
    endfunction

    function result_t status_only(status_t st);
      return '{8'h00, 1'b0, 1'b0, 1'b1, st};
    endfunction

    function result_t data_result(logic [7:0] b, logic pay, logic plast, logic klast);
      return '{b, pay, plast, klast, ST_DATA};
    endfunction

    function bit take_length(int unsigned total, output result_t r);
      r = '0;
      if (total == 0) begin
        r = status_only(ST_EMPTY);
        phase = SEEK_HEADER;
        return 1'b1;
      end
      if (total == 1) begin
        r = status_only(ST_MALFORMED);
        phase = SEEK_HEADER;
        return 1'b1;
      end
      bytes_left = 14'(total - 2);
      phase = TLEN_HIGH;
      return 1'b0;
    endfunction

    function void note_rx_byte(logic [7:0] b, logic bend);
      result_t     r;
      bit          produced;
      bit          done;
      logic [15:0] tlen;
      r = '0;
      produced = 1'b0;
      done = 1'b0;
      tlen = {tlen_high, b};
      // disabled: drop the byte and forget any partial packet
      if (!parse_enable) begin
        phase = SEEK_HEADER;
        return;
      end
      case (phase)
        LEN_FIRST: begin
          if (!b[7]) produced = take_length(b, r);
          else begin
            len_low = b[6:0];
            phase = LEN_SECOND;
          end
        end
        LEN_SECOND: begin
          if (b[7]) begin
            r = status_only(ST_MALFORMED);
            produced = 1'b1;
            phase = SEEK_HEADER;
          end else begin
            produced = take_length({b[6:0], len_low}, r);
          end
        end
        TLEN_HIGH: begin
          tlen_high = b;
          phase = TLEN_LOW;
        end
        TLEN_LOW: begin
          if (tlen > {2'b00, bytes_left}) begin
            r = status_only(ST_MALFORMED);
            produced = 1'b1;
            phase = SEEK_HEADER;
          end else begin
            topic_left = tlen;
            bytes_left = bytes_left - tlen[13:0];
            if (tlen == 0 && bytes_left == 0) begin
              r = status_only(ST_EMPTY);
              produced = 1'b1;
              phase = SEEK_HEADER;
            end else if (tlen == 0) begin
              phase = PAYLOAD_BYTES;
            end else begin
              phase = TOPIC_BYTES;
            end
          end
        end
        TOPIC_BYTES: begin
          if (topic_left != 0) topic_left = topic_left - 1'b1;
          if (topic_left == 0) begin
            done = (bytes_left == 0);
            r = data_result(b, 1'b0, 1'b1, done);
            phase = done ? SEEK_HEADER : PAYLOAD_BYTES;
          end else begin
            r = data_result(b, 1'b0, 1'b0, 1'b0);
          end
          produced = 1'b1;
        end
        PAYLOAD_BYTES: begin
          if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
          done = (bytes_left == 0);
          r = data_result(b, 1'b1, done, done);
          if (done) phase = SEEK_HEADER;
          produced = 1'b1;
        end
        default: begin
          phase = (b == PUBLISH_HEADER) ? LEN_FIRST : SEEK_HEADER;
        end
      endcase
      // buffer end cuts a started packet: abort replaces any data result
      if (bend && !done && phase != SEEK_HEADER) begin
        r = status_only(ST_ABORT);
        produced = 1'b1;
        phase = SEEK_HEADER;
      end
      if (produced) predicted_results.push_back(r);
    endfunction

    function void report(string what, result_t got, result_t want);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: got byte %02h pay %0d plast %0d klast %0d st %0d, expected byte %02h pay %0d plast %0d klast %0d st %0d",
                 $time, what, got.out_byte, got.in_payload, got.part_last, got.packet_last,
                 got.status, want.out_byte, want.in_payload, want.part_last,
                 want.packet_last, want.status);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_results.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      want = predicted_results.pop_front();
      if (got.out_byte !== want.out_byte || got.in_payload !== want.in_payload ||
          got.part_last !== want.part_last || got.packet_last !== want.packet_last ||
          got.status !== want.status)
        report("result mismatch", got, want);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  int unsigned idle_cycles;
  int unsigned burst_left;
  rx_item_t frame[$];
  publish_scoreboard board;

  mpd_in_if  rx_if ();
  mpd_out_if tx_if ();
  mpd_cfg_if cfg_if ();

  mqtt_publish_deframer i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if),
    .cfg (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (tx_if.valid && tx_if.ready)
        board.check_result('{tx_if.out_byte, tx_if.in_payload, tx_if.part_last,
                             tx_if.packet_last, tx_if.status});
      if (rx_if.valid && rx_if.ready) board.note_rx_byte(rx_if.rx_byte, rx_if.buffer_end);
      if (cfg_if.valid && cfg_if.ready) board.parse_enable = cfg_if.data;
    end
    if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t no request moved for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result side: a tick counter redraws the stall pattern; a hold request blocks it long
  initial begin
    int unsigned hold_left;
    int unsigned tick;
    sink_style_t style;
    bit          rdy;
    hold_left = 0;
    tick = 0;
    style = SINK_OPEN;
    tx_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 200 == 0) style = sink_style_t'($urandom_range(0, 3));
      if (hold_req) hold_left = HOLD_CYCLES;
      else if (hold_left != 0) hold_left--;
      case (style)
        SINK_OPEN:     rdy = 1'b1;
        SINK_RANDOM:   rdy = ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: rdy = ((tick % 7) > 2);
        default:       rdy = ($urandom_range(0, 3) == 0);
      endcase
      tx_if.ready <= rdy && (hold_left == 0);
    end
  end

  function automatic void put(logic [7:0] b, logic be);
    frame.push_back({be, b});
  endfunction

  function automatic void build_publish(int unsigned tl, int unsigned pl, bit long_form);
    int unsigned total;
    total = 2 + tl + pl;
    put(PUBLISH_HEADER, 1'b0);
    if (total > 127 || long_form) begin
      put({1'b1, 7'(total)}, 1'b0);
      put(8'(total >> 7), 1'b0);
    end else begin
      put(8'(total), 1'b0);
    end
    put(8'(tl >> 8), 1'b0);
    put(8'(tl), 1'b0);
    repeat (tl + pl) put(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // returns 0 for random noise bytes
  function automatic bit build_random_frame();
    int unsigned k;
    int unsigned total;
    int unsigned tl;
    int unsigned n;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      tl = $urandom_range(0, 6);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 260) : $urandom_range(0, 24);
      build_publish(tl, n, $urandom_range(0, 6) == 0);
      case ($urandom_range(0, 9))
        0: frame[$urandom_range(0, frame.size() - 1)][8] = 1'b1;
        1: frame[frame.size() - 1][8] = 1'b1;
        default: ;
      endcase
    end else if (k < 70) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return 1'b0;
    end else if (k < 76) begin
      // second length byte with continuation bit
      put(PUBLISH_HEADER, 1'b0);
      put(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
      put(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
    end else if (k < 82) begin
      put(PUBLISH_HEADER, 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        put(8'h80 | 8'($urandom_range(0, 1)), 1'b0);
        put(8'h00, 1'b0);
      end else begin
        put(8'($urandom_range(0, 1)), 1'b0);
      end
    end else if (k < 90) begin
      // topic length past the end of the packet
      total = $urandom_range(2, 20);
      tl = total - 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65000) : 0);
      put(PUBLISH_HEADER, 1'b0);
      put(8'(total), 1'b0);
      put(8'(tl >> 8), 1'b0);
      put(8'(tl), 1'b0);
    end else if (k < 96) begin
      // truncate without buffer end, leaving the parser mid-packet
      build_publish($urandom_range(0, 6), $urandom_range(0, 24), 1'b0);
      n = $urandom_range(1, frame.size() - 1);
      while (frame.size() > n) void'(frame.pop_back());
    end else begin
      // largest length, cut short by a buffer end
      put(PUBLISH_HEADER, 1'b0);
      put(8'hFF, 1'b0);
      put(8'h7F, 1'b0);
      put(8'($urandom_range(0, 63)), 1'b0);
      put(8'($urandom_range(0, 255)), 1'b0);
      repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)), 1'b0);
      frame[frame.size() - 1][8] = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b, logic be);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    rx_if.valid      <= 1'b1;
    rx_if.rx_byte    <= b;
    rx_if.buffer_end <= be;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i][7:0], frame[i][8]);
    frame.delete();
  endtask

  // drop valid and wait until the deframer has drained
  task automatic settle();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    while (board.predicted_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_parse_enable(logic on);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= on;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned items;
    int unsigned phase_no;
    int unsigned n;
    bit          on;
    bit          counts;
    board = new();
    burst_left = 0;
    rst              <= 1'b1;
    hold_req         <= 1'b0;
    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= 8'h00;
    rx_if.buffer_end <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // header while disabled is dropped
    put(PUBLISH_HEADER, 1'b0);
    send_frame();
    settle();
    write_parse_enable(1'b1);

    put(8'h00, 1'b0);
    put(PUBLISH_HEADER, 1'b0); put(8'h80, 1'b0); put(8'h80, 1'b0);
    put(PUBLISH_HEADER, 1'b0); put(8'h00, 1'b0);
    put(PUBLISH_HEADER, 1'b0); put(8'h01, 1'b0);
    put(PUBLISH_HEADER, 1'b0); put(8'h02, 1'b0); put(8'h00, 1'b0); put(8'h01, 1'b0);
    put(PUBLISH_HEADER, 1'b0); put(8'h02, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
    put(PUBLISH_HEADER, 1'b0); put(8'h03, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
    put(8'hFF, 1'b1);
    put(PUBLISH_HEADER, 1'b1);
    send_frame();
    settle();

    items = 0;
    phase_no = 0;
    while (items < 1450) begin
      if (phase_no == 1) on = 1'b0;
      else if (phase_no == 2) on = 1'b1;
      else on = ($urandom_range(0, 7) != 0);
      write_parse_enable(on);
      if (!on) begin
        repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_frame();
      end else begin
        if (phase_no == 2) begin
          // block the result side while a long packet keeps coming
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
          build_publish(3, 120, 1'b0);
          items += frame.size();
          send_frame();
        end
        n = $urandom_range(2, 10);
        repeat (n) begin
          counts = build_random_frame();
          if (counts) items += frame.size();
          send_frame();
        end
      end
      settle();
      phase_no++;
    end

    settle();
    if (board.mismatches == 0 && board.predicted_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0t mismatches %0d, results never seen %0d", $time, board.mismatches,
               board.predicted_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_if.sv
hw/rtl/mpd_step.sv
hw/rtl/mqtt_publish_deframer.sv
tb/mqtt_publish_deframer_tb.sv
